[hw/rtl/sik_pkg.sv]
// Shared types and constants for the sorted key index table.
`timescale 1ns / 1ps

package sik_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int KEY_BYTES   = 8;

  localparam int KEY_W   = 64;
  localparam int ADDR_W  = 31;
  localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
  localparam int CAP_W   = 7;
  localparam int CMP_W   = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam int OP_W    = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;

  localparam logic [KEY_W-1:0] KEY_MASK =
    64'hFFFF_FFFF_FFFF_FFFF >> (KEY_W - 8 * KEY_BYTES);

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_SEARCH = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_UNIQUE_KEYS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY    = 1'b1;

  localparam logic [CAP_W-1:0] CAPACITY_RESET = 7'd64;

  typedef enum logic {
    ST_IDLE,
    ST_UPDATE
  } sik_state_t;

  typedef struct packed {
    logic cmp;
    logic ins;
    logic rem;
  } sik_cell_ctrl_t;

endpackage

[hw/rtl/sorted_key_index_table.sv]
// Top level of the sorted key index table: control, configuration and the row of cells.
//
// Usage: raise start with opcode, key and record_address while busy is low;
// the command is taken at that clock edge. Every cell compares its key with
// the command key in that same cycle. busy is then high for one cycle, in
// which all cells shift at once (insert moves entries not below the key up,
// remove closes the gap) and the entry count is updated. In the cycle after,
// done is high for exactly one cycle with status, found_address and entry_count.
// A command thus runs through the compare cycle and the update cycle of the
// control sequence, and a new start is taken in the cycle done shows.
// Configuration beats on cfg_valid/cfg_ready (always ready) write
// unique_keys (index 0) or capacity (index 1); write them only while idle.
// Reset empties the table, sets unique_keys to 1 and capacity to 64.
// The receiver cannot stall; each result beat must be taken when done is high.
`timescale 1ns / 1ps

module sorted_key_index_table
  import sik_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [OP_W-1:0]       opcode,
  input  logic [KEY_W-1:0]      key,
  input  logic [ADDR_W-1:0]     record_address,
  output logic                  done,
  output logic                  status,
  output logic [ADDR_W-1:0]     found_address,
  output logic [CNT_W-1:0]      entry_count,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  sik_state_t        state;
  sik_state_t        state_next;
  logic [OP_W-1:0]   op_q;
  logic [KEY_W-1:0]  key_q;
  logic [ADDR_W-1:0] addr_q;
  logic [CNT_W-1:0]  entry_total;
  logic [CNT_W-1:0]  entry_total_next;
  logic              unique_keys;
  logic [CAP_W-1:0]  capacity;

  logic              status_next;
  logic [ADDR_W-1:0] found_next;
  logic              hit;
  logic              ins_ok;
  logic              accept;
  sik_cell_ctrl_t    ctrl;

  logic [KEY_W-1:0]       probe_key;
  logic [KEY_W-1:0]       ck [TABLE_DEPTH];
  logic [ADDR_W-1:0]      ca [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] lt_vec;
  logic [TABLE_DEPTH-1:0] match_vec;
  logic [TABLE_DEPTH-1:0] occ;

  assign accept    = start && (state == ST_IDLE);
  assign busy      = (state == ST_UPDATE);
  assign cfg_ready = 1'b1;
  assign probe_key = key & KEY_MASK;

  genvar gi;
  generate
    for (gi = 0; gi < TABLE_DEPTH; gi++) begin : g_cell
      logic              l_lt;
      logic [KEY_W-1:0]  l_key;
      logic [ADDR_W-1:0] l_addr;
      logic [KEY_W-1:0]  r_key;
      logic [ADDR_W-1:0] r_addr;

      assign occ[gi] = (CNT_W'(gi) < entry_total);

      if (gi == 0) begin : g_first
        assign l_lt   = 1'b1;
        assign l_key  = key_q;
        assign l_addr = addr_q;
      end else begin : g_mid
        assign l_lt   = lt_vec[gi-1];
        assign l_key  = ck[gi-1];
        assign l_addr = ca[gi-1];
      end

      if (gi == TABLE_DEPTH - 1) begin : g_last
        assign r_key  = ck[gi];
        assign r_addr = ca[gi];
      end else begin : g_inner
        assign r_key  = ck[gi+1];
        assign r_addr = ca[gi+1];
      end

      sik_cell u_cell (
        .clk        (clk),
        .ctrl       (ctrl),
        .occupied   (occ[gi]),
        .probe_key  (probe_key),
        .new_key    (key_q),
        .new_addr   (addr_q),
        .left_lt    (l_lt),
        .left_key   (l_key),
        .left_addr  (l_addr),
        .right_key  (r_key),
        .right_addr (r_addr),
        .cell_key   (ck[gi]),
        .cell_addr  (ca[gi]),
        .lt         (lt_vec[gi]),
        .match      (match_vec[gi])
      );
    end
  endgenerate

  always_comb begin
    found_next = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      found_next = found_next | (ca[i] & {ADDR_W{match_vec[i]}});
    end
  end

  assign hit    = |match_vec;
  assign ins_ok = !(unique_keys && hit)
                  && (CMP_W'(entry_total) < CMP_W'(capacity))
                  && (entry_total < CNT_W'(TABLE_DEPTH));

  always_comb begin
    state_next       = state;
    entry_total_next = entry_total;
    status_next      = 1'b1;
    ctrl.cmp         = accept;
    ctrl.ins         = 1'b0;
    ctrl.rem         = 1'b0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        state_next = ST_IDLE;
        case (op_q)
          OP_INSERT: begin
            if (ins_ok) begin
              ctrl.ins         = 1'b1;
              entry_total_next = entry_total + CNT_W'(1);
              status_next      = 1'b0;
            end
          end
          OP_REMOVE: begin
            if (hit) begin
              ctrl.rem         = 1'b1;
              entry_total_next = entry_total - CNT_W'(1);
              status_next      = 1'b0;
            end
          end
          OP_SEARCH: begin
            status_next = !hit;
          end
          default: begin
            status_next = 1'b1;
          end
        endcase
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      entry_total <= '0;
      done        <= 1'b0;
    end else begin
      state       <= state_next;
      entry_total <= entry_total_next;
      done        <= busy;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      unique_keys <= 1'b1;
      capacity    <= CAPACITY_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_UNIQUE_KEYS: unique_keys <= cfg_data[0];
        REG_CAPACITY:    capacity    <= cfg_data[CAP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q   <= opcode;
      key_q  <= probe_key;
      addr_q <= record_address;
    end
    if (busy) begin
      status        <= status_next;
      found_address <= (op_q == OP_SEARCH && hit) ? found_next : '0;
      entry_count   <= entry_total_next;
    end
  end

endmodule

[hw/rtl/sik_cell.sv]
// One table cell: holds a key and record address, compares and shifts with its neighbors.
`timescale 1ns / 1ps

module sik_cell
  import sik_pkg::*;
(
  input  logic                 clk,
  input  sik_cell_ctrl_t       ctrl,
  input  logic                 occupied,
  input  logic [KEY_W-1:0]     probe_key,
  input  logic [KEY_W-1:0]     new_key,
  input  logic [ADDR_W-1:0]    new_addr,
  input  logic                 left_lt,
  input  logic [KEY_W-1:0]     left_key,
  input  logic [ADDR_W-1:0]    left_addr,
  input  logic [KEY_W-1:0]     right_key,
  input  logic [ADDR_W-1:0]    right_addr,
  output logic [KEY_W-1:0]     cell_key,
  output logic [ADDR_W-1:0]    cell_addr,
  output logic                 lt,
  output logic                 match
);

  logic [KEY_W-1:0]  stored_key;
  logic [ADDR_W-1:0] stored_addr;
  logic              lt_q;
  logic              eq_q;
  logic              first;

  assign first = !lt_q && left_lt;

  always_ff @(posedge clk) begin
    if (ctrl.cmp) begin
      lt_q <= occupied && (stored_key < probe_key);
      eq_q <= occupied && (stored_key == probe_key);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.ins) begin
      if (!left_lt) begin
        stored_key  <= left_key;
        stored_addr <= left_addr;
      end else if (!lt_q) begin
        stored_key  <= new_key;
        stored_addr <= new_addr;
      end
    end else if (ctrl.rem) begin
      if (!lt_q) begin
        stored_key  <= right_key;
        stored_addr <= right_addr;
      end
    end
  end

  assign cell_key  = stored_key;
  assign cell_addr = stored_addr;
  assign lt        = lt_q;
  assign match     = first && eq_q;

endmodule

[hw/rtl/sik_checker.sv]
// Port-level checks for the sorted key index table and their binding to the top level.
`timescale 1ns / 1ps

module sik_checker
  import sik_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic              done,
  input logic              status,
  input logic [ADDR_W-1:0] found_address,
  input logic [CNT_W-1:0]  entry_count
);

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted command did not raise busy");

  a_busy_done: assert property (@(posedge clk) disable iff (rst)
    busy |=> done && !busy)
    else $error("update cycle was not followed by a result beat");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy && $past(busy))
    else $error("result beat without a preceding update cycle");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    done && status |-> found_address == '0)
    else $error("refused or missed command reported an address");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    done |-> entry_count <= CNT_W'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

endmodule

bind sorted_key_index_table sik_checker u_sik_checker (.*);
